// ===== src/cpu8_pkg.sv =====
// ---------------------------------------------------------------------------
// cpu8_pkg
// Shared types and constants for the 8-bit CPU execute unit.
// ---------------------------------------------------------------------------
package cpu8_pkg;

   // flag_bits layout: N V D I Z C from bit 5 down to bit 0
   localparam int FL_N = 5;
   localparam int FL_V = 4;
   localparam int FL_D = 3;
   localparam int FL_I = 2;
   localparam int FL_Z = 1;
   localparam int FL_C = 0;

   localparam logic [7:0] SP_RESET    = 8'hFD;
   localparam logic [5:0] FLAG_RESET  = 6'h04;

   // architectural state
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] xreg;
      logic [7:0] yreg;
      logic [7:0] sp;
      logic [5:0] flags;
   } arch_type;

   // one result item
   typedef struct packed {
      logic       write_enable;
      logic [7:0] write_data;
      logic       branch_taken;
      logic [7:0] stack_slot;
      logic       unsupported;
   } side_type;

endpackage

// ===== src/cpu8_alu.sv =====
// ---------------------------------------------------------------------------
// cpu8_alu
// Decodes one opcode and computes the next register state and side results.
// ---------------------------------------------------------------------------
module cpu8_alu (
   input  logic [7:0]        action,
   input  logic [7:0]        operand,
   input  cpu8_pkg::arch_type cur,
   output cpu8_pkg::arch_type nxt,
   output cpu8_pkg::side_type side
);
   import cpu8_pkg::*;

   logic [8:0] sum;
   logic [7:0] addend;
   logic [7:0] res;
   logic [7:0] cmp_reg;
   logic [7:0] sh_in;
   logic [7:0] sh_out;
   logic       sh_c;
   logic       flag_sel;
   logic [7:0] status_b;

   // opcodes that leave N and Z alone (besides BIT, branches, bad opcodes)
   function automatic logic updates_nz(input logic [7:0] op);
      case (op)
         8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91,
         8'h86, 8'h96, 8'h8E, 8'h84, 8'h94, 8'h8C,
         8'h9A, 8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8,
         8'h48, 8'h08, 8'h28, 8'hEA: updates_nz = 1'b0;
         default: updates_nz = 1'b1;
      endcase
   endfunction

   always_comb begin
      // shifter: kind from opcode bits 6:5
      sh_in = (action[3:0] == 4'hA) ? cur.acc : operand;
      case (action[6:5])
         2'd0: begin sh_out = {sh_in[6:0], 1'b0};        sh_c = sh_in[7]; end
         2'd1: begin sh_out = {sh_in[6:0], cur.flags[FL_C]}; sh_c = sh_in[7]; end
         2'd2: begin sh_out = {1'b0, sh_in[7:1]};        sh_c = sh_in[0]; end
         default: begin sh_out = {cur.flags[FL_C], sh_in[7:1]}; sh_c = sh_in[0]; end
      endcase
      addend   = action[7] ? ~operand : operand;
      sum      = {1'b0, cur.acc} + {1'b0, addend} + {8'd0, cur.flags[FL_C]};
      status_b = {cur.flags[FL_N], cur.flags[FL_V], 2'b11, cur.flags[FL_D],
                  cur.flags[FL_I], cur.flags[FL_Z], cur.flags[FL_C]};
      case (action[7:6])
         2'd0: flag_sel = cur.flags[FL_N];
         2'd1: flag_sel = cur.flags[FL_V];
         2'd2: flag_sel = cur.flags[FL_C];
         default: flag_sel = cur.flags[FL_Z];
      endcase
      cmp_reg = cur.acc;
      res     = 8'd0;
      nxt     = cur;
      side    = '0;

      if (action[4:0] == 5'h10) begin
         side.branch_taken = (flag_sel == action[5]);
      end else begin
         case (action)
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71,
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: begin
               res = sum[7:0];
               nxt.acc = res;
               nxt.flags[FL_C] = sum[8];
               nxt.flags[FL_V] = (cur.acc[7] ^ res[7]) & (addend[7] ^ res[7]);
            end
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: begin
               res = cur.acc & operand; nxt.acc = res;
            end
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: begin
               res = cur.acc | operand; nxt.acc = res;
            end
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: begin
               res = cur.acc ^ operand; nxt.acc = res;
            end
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1,
            8'hE0, 8'hE4, 8'hEC, 8'hC0, 8'hC4, 8'hCC: begin
               if (action == 8'hE0 || action == 8'hE4 || action == 8'hEC) cmp_reg = cur.xreg;
               else if (action == 8'hC0 || action == 8'hC4 || action == 8'hCC)
                  cmp_reg = cur.yreg;
               res = cmp_reg - operand;
               nxt.flags[FL_C] = (cmp_reg >= operand);
            end
            8'h24, 8'h2C: begin
               res = 8'd0;
            end
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: begin
               res = operand; nxt.acc = res;
            end
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin res = operand; nxt.xreg = res; end
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin res = operand; nxt.yreg = res; end
            8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: begin
               side.write_enable = 1'b1; side.write_data = cur.acc;
            end
            8'h86, 8'h96, 8'h8E: begin side.write_enable = 1'b1; side.write_data = cur.xreg; end
            8'h84, 8'h94, 8'h8C: begin side.write_enable = 1'b1; side.write_data = cur.yreg; end
            8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
               res = operand - 8'd1; side.write_enable = 1'b1; side.write_data = res;
            end
            8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
               res = operand + 8'd1; side.write_enable = 1'b1; side.write_data = res;
            end
            8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
               res = sh_out; nxt.acc = res; nxt.flags[FL_C] = sh_c;
            end
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
               res = sh_out; nxt.flags[FL_C] = sh_c;
               side.write_enable = 1'b1; side.write_data = res;
            end
            8'hCA: begin res = cur.xreg - 8'd1; nxt.xreg = res; end
            8'h88: begin res = cur.yreg - 8'd1; nxt.yreg = res; end
            8'hE8: begin res = cur.xreg + 8'd1; nxt.xreg = res; end
            8'hC8: begin res = cur.yreg + 8'd1; nxt.yreg = res; end
            8'hAA: begin res = cur.acc;  nxt.xreg = res; end
            8'hA8: begin res = cur.acc;  nxt.yreg = res; end
            8'hBA: begin res = cur.sp;   nxt.xreg = res; end
            8'h8A: begin res = cur.xreg; nxt.acc = res; end
            8'h98: begin res = cur.yreg; nxt.acc = res; end
            8'h9A: nxt.sp = cur.xreg;
            8'h18: nxt.flags[FL_C] = 1'b0;
            8'h38: nxt.flags[FL_C] = 1'b1;
            8'h58: nxt.flags[FL_I] = 1'b0;
            8'h78: nxt.flags[FL_I] = 1'b1;
            8'hB8: nxt.flags[FL_V] = 1'b0;
            8'hD8: nxt.flags[FL_D] = 1'b0;
            8'hF8: nxt.flags[FL_D] = 1'b1;
            8'h48, 8'h08: begin
               side.write_enable = 1'b1;
               side.write_data   = action[6] ? cur.acc : status_b;
               side.stack_slot   = cur.sp;
               nxt.sp = cur.sp - 8'd1;
            end
            8'h68: begin
               nxt.sp = cur.sp + 8'd1; side.stack_slot = nxt.sp;
               res = operand; nxt.acc = res;
            end
            8'h28: begin
               nxt.sp = cur.sp + 8'd1; side.stack_slot = nxt.sp;
               nxt.flags = {operand[7], operand[6], operand[3:0]};
            end
            8'hEA: ;
            default: side.unsupported = 1'b1;
         endcase
      end

      // N and Z from the result where the instruction sets them
      case (action)
         8'h24, 8'h2C: begin
            nxt.flags[FL_Z] = ((cur.acc & operand) == 8'd0);
            nxt.flags[FL_N] = operand[7];
            nxt.flags[FL_V] = operand[6];
         end
         default: begin
            if (!side.unsupported && action[4:0] != 5'h10 && updates_nz(action)) begin
               nxt.flags[FL_N] = res[7];
               nxt.flags[FL_Z] = (res == 8'd0);
            end
         end
      endcase
   end

endmodule

// ===== src/cpu8_execute_unit_top.sv =====
// ---------------------------------------------------------------------------
// cpu8_execute_unit_top
// Execute stage of an 8-bit CPU: one instruction per item, registered result.
// ---------------------------------------------------------------------------
// Channel | Dir | Contents
// req     | in  | tdata[7:0] action, tdata[15:8] operand
// rsp     | out | tdata: write_enable, write_data, branch_taken, stack_slot,
//         |     |        unsupported, acc, x, y, sp, status (59 bits, zero-filled to 64)
//
// One item per cycle while the result side is not stalled; a result appears the
// cycle after its item is taken.
// Reset clears A, X, Y, sets SP to 0xFD and leaves only I set.
// A stalled result holds; an item is taken whenever the result register is
// empty or being emptied in the same cycle.
module cpu8_execute_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] action, [15:8] operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] write_enable, [8:1] write_data, [9] branch_taken, [17:10] stack_slot,
   // [18] unsupported, [26:19] acc_value, [34:27] xreg_value,
   // [42:35] yreg_value, [50:43] stack_ptr_value, [58:51] status_value
   output logic [63:0] rsp_tdata
);
   import cpu8_pkg::*;

   arch_type   state_ff, state_in;
   side_type   side_in, side_ff;
   logic       valid_ff;
   logic       take;

   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   cpu8_alu u_alu (
      .action (req_tdata[7:0]),
      .operand(req_tdata[15:8]),
      .cur    (state_ff),
      .nxt    (state_in),
      .side   (side_in)
   );

   // advance architectural state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{acc: 8'd0, xreg: 8'd0, yreg: 8'd0, sp: SP_RESET, flags: FLAG_RESET};
         valid_ff <= 1'b0;
      end else begin
         if (take) state_ff <= state_in;
         if (take) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   // hold side results with the item
   always_ff @(posedge clock) begin
      if (take) side_ff <= side_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0,
      state_ff.flags[FL_N], state_ff.flags[FL_V], 2'b10, state_ff.flags[FL_D],
      state_ff.flags[FL_I], state_ff.flags[FL_Z], state_ff.flags[FL_C],
      state_ff.sp, state_ff.yreg, state_ff.xreg, state_ff.acc,
      side_ff.unsupported, side_ff.stack_slot, side_ff.branch_taken,
      side_ff.write_data, side_ff.write_enable};

   // a stalled result keeps its state
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(state_ff)) else $error("state moved in stall");
   // unsupported leaves the state unchanged
   a_bad: assert property (@(posedge clock) disable iff (reset)
      take && side_in.unsupported |=> $stable(state_ff)) else $error("bad opcode changed state");
   // nothing is written by an unsupported opcode
   a_nowr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && side_ff.unsupported |-> !side_ff.write_enable)
      else $error("write on bad opcode");

endmodule

// ===== tb/cpu8_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cpu8_result_checker
// Watches both channels of the execute unit, runs its own model of the
// register file and flags for every item taken, and compares each result.
// ---------------------------------------------------------------------------
module cpu8_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] action, [15:8] operand
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // we, wd, bt, slot, unsup, a, x, y, sp, p
   output int          fail_count,
   output int          pending_count
);
   import cpu8_pkg::*;

   // highest field first so that write_enable lands in bit 0
   typedef struct packed {
      logic [7:0] status_value;
      logic [7:0] sp_value;
      logic [7:0] yreg_value;
      logic [7:0] xreg_value;
      logic [7:0] acc_value;
      logic       unsupported;
      logic [7:0] stack_slot;
      logic       branch_taken;
      logic [7:0] write_data;
      logic       write_enable;
   } outcome_type;

   arch_type    regs;
   outcome_type expected_outcomes[$];

   assign pending_count = expected_outcomes.size();

   function automatic logic [7:0] status_byte(logic [5:0] f);
      return {f[FL_N], f[FL_V], 1'b1, 1'b0, f[FL_D], f[FL_I], f[FL_Z], f[FL_C]};
   endfunction

   function automatic logic [7:0] set_nz(inout arch_type r, input logic [7:0] v);
      r.flags[FL_N] = v[7];
      r.flags[FL_Z] = (v == 8'h00);
      return v;
   endfunction

   function automatic void add_carry(inout arch_type r, input logic [7:0] m);
      logic [8:0] sum;
      sum = {1'b0, r.acc} + {1'b0, m} + {8'h00, r.flags[FL_C]};
      r.flags[FL_C] = sum[8];
      r.flags[FL_V] = ((r.acc ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 0;
      r.acc = set_nz(r, sum[7:0]);
   endfunction

   function automatic void compare_reg(inout arch_type r, input logic [7:0] a,
                                       input logic [7:0] m);
      r.flags[FL_C] = (a >= m);
      void'(set_nz(r, a - m));
   endfunction

   // kind: 0 asl, 1 rol, 2 lsr, 3 ror
   function automatic logic [7:0] shift_val(inout arch_type r, input logic [1:0] kind,
                                            input logic [7:0] v);
      logic       cin;
      logic [7:0] res;
      cin = r.flags[FL_C];
      if (kind < 2) begin
         res = {v[6:0], (kind == 1) ? cin : 1'b0};
         r.flags[FL_C] = v[7];
      end else begin
         res = {(kind == 3) ? cin : 1'b0, v[7:1]};
         r.flags[FL_C] = v[0];
      end
      return set_nz(r, res);
   endfunction

   function automatic outcome_type execute_op(inout arch_type r, input logic [7:0] op,
                                              input logic [7:0] m);
      outcome_type o;
      logic        f;
      o = '0;
      if (op[4:0] == 5'h10) begin
         case (op[7:6])
            2'd0: f = r.flags[FL_N];
            2'd1: f = r.flags[FL_V];
            2'd2: f = r.flags[FL_C];
            default: f = r.flags[FL_Z];
         endcase
         o.branch_taken = (f == op[5]);
      end else begin
         case (op)
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: add_carry(r, m);
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: add_carry(r, ~m);
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31:
               r.acc = set_nz(r, r.acc & m);
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11:
               r.acc = set_nz(r, r.acc | m);
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51:
               r.acc = set_nz(r, r.acc ^ m);
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1:
               compare_reg(r, r.acc, m);
            8'hE0, 8'hE4, 8'hEC: compare_reg(r, r.xreg, m);
            8'hC0, 8'hC4, 8'hCC: compare_reg(r, r.yreg, m);
            8'h24, 8'h2C: begin
               r.flags[FL_Z] = ((r.acc & m) == 0);
               r.flags[FL_N] = m[7];
               r.flags[FL_V] = m[6];
            end
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: r.acc = set_nz(r, m);
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: r.xreg = set_nz(r, m);
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: r.yreg = set_nz(r, m);
            8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: begin
               o.write_enable = 1'b1; o.write_data = r.acc;
            end
            8'h86, 8'h96, 8'h8E: begin o.write_enable = 1'b1; o.write_data = r.xreg; end
            8'h84, 8'h94, 8'h8C: begin o.write_enable = 1'b1; o.write_data = r.yreg; end
            8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
               o.write_enable = 1'b1; o.write_data = set_nz(r, m - 8'd1);
            end
            8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
               o.write_enable = 1'b1; o.write_data = set_nz(r, m + 8'd1);
            end
            8'h0A, 8'h2A, 8'h4A, 8'h6A: r.acc = shift_val(r, op[6:5], r.acc);
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
               o.write_enable = 1'b1; o.write_data = shift_val(r, op[6:5], m);
            end
            8'hCA: r.xreg = set_nz(r, r.xreg - 8'd1);
            8'h88: r.yreg = set_nz(r, r.yreg - 8'd1);
            8'hE8: r.xreg = set_nz(r, r.xreg + 8'd1);
            8'hC8: r.yreg = set_nz(r, r.yreg + 8'd1);
            8'hAA: r.xreg = set_nz(r, r.acc);
            8'hA8: r.yreg = set_nz(r, r.acc);
            8'hBA: r.xreg = set_nz(r, r.sp);
            8'h8A: r.acc = set_nz(r, r.xreg);
            8'h98: r.acc = set_nz(r, r.yreg);
            8'h9A: r.sp = r.xreg;
            8'h18: r.flags[FL_C] = 1'b0;
            8'h38: r.flags[FL_C] = 1'b1;
            8'h58: r.flags[FL_I] = 1'b0;
            8'h78: r.flags[FL_I] = 1'b1;
            8'hB8: r.flags[FL_V] = 1'b0;
            8'hD8: r.flags[FL_D] = 1'b0;
            8'hF8: r.flags[FL_D] = 1'b1;
            8'h48, 8'h08: begin
               o.write_enable = 1'b1;
               o.write_data = (op == 8'h48) ? r.acc : (status_byte(r.flags) | 8'h30);
               o.stack_slot = r.sp;
               r.sp = r.sp - 8'd1;
            end
            8'h68, 8'h28: begin
               r.sp = r.sp + 8'd1;
               o.stack_slot = r.sp;
               if (op == 8'h68) r.acc = set_nz(r, m);
               else r.flags = {m[7], m[6], m[3], m[2], m[1], m[0]};
            end
            8'hEA: ;
            default: o.unsupported = 1'b1;
         endcase
      end
      o.acc_value    = r.acc;
      o.xreg_value   = r.xreg;
      o.yreg_value   = r.yreg;
      o.sp_value     = r.sp;
      o.status_value = status_byte(r.flags);
      return o;
   endfunction

   // Predict on item accept, compare on result accept
   always @(posedge clock) begin
      outcome_type exp_o, got_o;
      if (reset) begin
         regs <= '{acc: 8'h00, xreg: 8'h00, yreg: 8'h00, sp: SP_RESET, flags: FLAG_RESET};
         expected_outcomes.delete();
         fail_count <= 0;
      end else begin
         arch_type r;
         r = regs;
         if (rsp_tvalid && rsp_tready) begin
            got_o = rsp_tdata[58:0];
            if (expected_outcomes.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_o = expected_outcomes.pop_front();
               if (got_o !== exp_o || rsp_tdata[63:59] !== 5'd0) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %h, actual %h", exp_o, got_o);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(execute_op(r, req_tdata[7:0], req_tdata[15:8]));
            regs <= r;
         end
      end
   end
endmodule

// ===== tb/tb_cpu8_execute_unit_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cpu8_execute_unit_top
// Drives instruction items into the execute unit with random gaps on both
// channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_cpu8_execute_unit_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] action, [15:8] operand
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // result fields, write_enable lowest
   int          fail_count;
   int          pending_count;

   logic [7:0] directed_ops[] = '{8'hA9, 8'h69, 8'h69, 8'hE9, 8'hC9, 8'h24, 8'h0A, 8'h2A,
      8'h4A, 8'h6A, 8'h26, 8'h66, 8'h48, 8'h08, 8'h68, 8'h28, 8'h9A, 8'h28, 8'h68,
      8'h59, 8'hF8, 8'h69, 8'h00, 8'h4C, 8'hD0};
   logic [7:0] directed_vals[] = '{8'h7F, 8'h01, 8'hFF, 8'h80, 8'h00, 8'hC0, 8'h00, 8'h81,
      8'h00, 8'h00, 8'h80, 8'h01, 8'h00, 8'h00, 8'h55, 8'hFF, 8'h00, 8'h00, 8'h00,
      8'hAA, 8'h00, 8'h99, 8'h00, 8'h12, 8'h00};

   always #10 clock = ~clock;

   cpu8_execute_unit_top dut (.*);

   cpu8_result_checker checker_i (.*);

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
   endfunction

   // Send one item and hold it until taken
   task automatic send_item(input logic [7:0] op, input logic [7:0] val, input bit idle);
      int g;
      if (idle) begin
         g = gap_len();
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Randomise result-side back-pressure
   initial begin
      @(negedge clock);
      forever begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 40) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(5, 30)) @(negedge clock);
         end else @(negedge clock);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_ops[i]) send_item(directed_ops[i], directed_vals[i], 1'b0);
      for (int i = 0; i < 1050; i++) begin
         if (i == 500) begin
            req_tvalid <= 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   (i % 200) > 60);
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0 && !rsp_tvalid)
         $display("tb_cpu8_execute_unit_top: done, clean");
      else
         $display("tb_cpu8_execute_unit_top: done, errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_cpu8_execute_unit_top: done, errors");
      $finish;
   end
endmodule
